// ----- design/jes_pkg.sv -----
// ----------------------------------------------------------------------------
// jes_pkg: shared constants, types and helpers
// Fixed-point widths, store geometry and the control structs that pass
// between the solver core, the multiply-accumulate unit and the CORDIC.
// ----------------------------------------------------------------------------
package jes_pkg;

    localparam int DATA_W        = 32;
    localparam int THR_W         = 31;
    localparam int SIZE_W        = 4;
    localparam int MAX_DIM       = 8;
    localparam int DIM_W         = $clog2(MAX_DIM);
    localparam int ADDR_W        = 2 * DIM_W;
    localparam int DEPTH         = MAX_DIM * MAX_DIM;
    localparam int MAX_ROTATIONS = 256;
    localparam int ROT_W         = $clog2(MAX_ROTATIONS + 1);

    localparam int CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 1'b1;
    localparam logic [THR_W-1:0]     THRESHOLD_RST = 31'd168;
    localparam logic [SIZE_W-1:0]    SIZE_RST      = 4'd3;

    localparam int OUT_DATA_W    = 72;

    // multiply-accumulate geometry
    localparam int MAC_A_W       = DATA_W + 2;
    localparam int PROD_W        = MAC_A_W + DATA_W;
    localparam int ACC_W         = PROD_W + 2;

    // CORDIC geometry
    localparam int CORDIC_W      = 48;
    localparam int CS_W          = 34;
    localparam int CORDIC_STEPS  = 31;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);
    localparam logic signed [CS_W-1:0] Q30_ONE     = {4'b0001, 30'b0};
    localparam logic signed [CS_W-1:0] CORDIC_KINV = {2'b00, 32'h26DD3B6A};
    localparam logic signed [CORDIC_W-1:0] NORM_LIMIT =
        {{(CORDIC_W-41){1'b0}}, 1'b1, 40'b0};

    localparam logic signed [DATA_W-1:0] Q24_ONE = 32'sh0100_0000;

    typedef struct packed {
        logic mul;
        logic acc;
        logic first;
        logic neg;
        logic dbl;
    } mac_ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] s;
    } rot_t;

    typedef struct packed {
        logic [DIM_W-1:0]         pair_index;
        logic [DIM_W-1:0]         component_index;
        logic signed [DATA_W-1:0] eigenvalue;
        logic signed [DATA_W-1:0] component;
        logic                     converged;
        logic                     last;
    } res_t;

    function automatic logic [ADDR_W-1:0] mk_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
        return {r, c};
    endfunction

endpackage

// ----- design/jes_mac.sv -----
// ----------------------------------------------------------------------------
// jes_mac: shared multiply-accumulate unit
// One registered signed product per cycle while mul is set, accumulated exactly, with a
// floor and a rounded, saturated Q30 read-out of the accumulator.
// ----------------------------------------------------------------------------
module jes_mac (
    input  logic                                 aclk,
    input  logic signed [jes_pkg::MAC_A_W-1:0]   op_a,
    input  logic signed [jes_pkg::DATA_W-1:0]    op_b,
    input  jes_pkg::mac_ctrl_t                   ctrl,
    output logic signed [jes_pkg::DATA_W-1:0]    floor_q,
    output logic signed [jes_pkg::DATA_W-1:0]    round_q
);
    import jes_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF_LSB = {{(ACC_W-30){1'b0}}, 1'b1, 29'b0};
    localparam logic signed [ACC_W-1:0] SAT_HI   = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO   = {{(ACC_W-31){1'b1}}, 31'b0};

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shifted;

    always_comb begin
        addend = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (ctrl.dbl) begin
            addend = addend <<< 1;
        end
        if (ctrl.neg) begin
            addend = -addend;
        end
        acc_next = (ctrl.first ? '0 : acc_reg) + addend;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.acc) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        rnd     = acc_reg + HALF_LSB;
        shifted = rnd >>> 30;
        floor_q = acc_reg[61:30];
        if (shifted > SAT_HI) begin
            round_q = 32'sh7FFF_FFFF;
        end else if (shifted < SAT_LO) begin
            round_q = 32'sh8000_0000;
        end else begin
            round_q = shifted[DATA_W-1:0];
        end
    end

endmodule

// ----- design/jes_cordic.sv -----
// ----------------------------------------------------------------------------
// jes_cordic: half-angle cos/sin by iterative vectoring CORDIC
// Normalises (x, y) by doubling, then drives (x, y) towards the axis with
// a double step while a unit vector turns by the single angle.
// ----------------------------------------------------------------------------
module jes_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [jes_pkg::DATA_W:0]     x_in,
    input  logic signed [jes_pkg::DATA_W:0]     y_in,
    output logic                                done,
    output jes_pkg::rot_t                       result
);
    import jes_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_NORM = 4'b0010,
        C_ROT  = 4'b0100,
        C_DONE = 4'b1000
    } cst_t;

    cst_t                      cst_reg, cst_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [CS_W-1:0]     c_reg, c_next, s_reg, s_next;
    logic [STEP_W-1:0]          k_reg, k_next;
    logic                       ph_reg, ph_next, pos_reg, pos_next;
    logic                       dir;
    logic                       below_lim;
    logic signed [CORDIC_W-1:0] xs, ys;

    always_comb begin
        cst_next = cst_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        c_next   = c_reg;
        s_next   = s_reg;
        k_next   = k_reg;
        ph_next  = ph_reg;
        pos_next = pos_reg;
        dir      = ph_reg ? pos_reg : (y_reg >= 0);
        xs       = x_reg >>> k_reg;
        ys       = y_reg >>> k_reg;
        below_lim = (x_reg > -NORM_LIMIT) && (x_reg < NORM_LIMIT) &&
                    (y_reg > -NORM_LIMIT) && (y_reg < NORM_LIMIT);
        unique case (cst_reg)
            C_IDLE: begin
                if (start) begin
                    x_next = {{(CORDIC_W-DATA_W-1){x_in[DATA_W]}}, x_in};
                    y_next = {{(CORDIC_W-DATA_W-1){y_in[DATA_W]}}, y_in};
                    if (x_in == '0 && y_in == '0) begin
                        c_next   = Q30_ONE;
                        s_next   = '0;
                        cst_next = C_DONE;
                    end else begin
                        cst_next = C_NORM;
                    end
                end
            end
            C_NORM: begin
                if (below_lim) begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end else begin
                    c_next   = CORDIC_KINV;
                    s_next   = '0;
                    k_next   = '0;
                    ph_next  = 1'b0;
                    cst_next = C_ROT;
                end
            end
            C_ROT: begin
                x_next  = dir ? x_reg + ys : x_reg - ys;
                y_next  = dir ? y_reg - xs : y_reg + xs;
                ph_next = ~ph_reg;
                if (!ph_reg) begin
                    // single turn of the unit vector on the first half-step
                    pos_next = dir;
                    c_next   = dir ? c_reg - (s_reg >>> k_reg) : c_reg + (s_reg >>> k_reg);
                    s_next   = dir ? s_reg + (c_reg >>> k_reg) : s_reg - (c_reg >>> k_reg);
                end else if (k_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    cst_next = C_DONE;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            C_DONE: begin
                cst_next = C_IDLE;
            end
            default: begin
                cst_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cst_reg <= C_IDLE;
        end else begin
            cst_reg <= cst_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        c_reg   <= c_next;
        s_reg   <= s_next;
        k_reg   <= k_next;
        ph_reg  <= ph_next;
        pos_reg <= pos_next;
    end

    assign done = (cst_reg == C_DONE);

    always_comb begin
        if (c_reg > Q30_ONE) begin
            result.c = Q30_ONE[DATA_W-1:0];
        end else if (c_reg < -Q30_ONE) begin
            result.c = DATA_W'(-Q30_ONE);
        end else begin
            result.c = c_reg[DATA_W-1:0];
        end
        if (s_reg > Q30_ONE) begin
            result.s = Q30_ONE[DATA_W-1:0];
        end else if (s_reg < -Q30_ONE) begin
            result.s = DATA_W'(-Q30_ONE);
        end else begin
            result.s = s_reg[DATA_W-1:0];
        end
    end

endmodule

// ----- design/jes_core.sv -----
// ----------------------------------------------------------------------------
// jes_core: Jacobi sequencer around the matrix and vector stores
// Loads the matrix, sweeps the vector store to identity, then repeats
// search, angle and rotate passes by read-modify-write, and streams out.
// ----------------------------------------------------------------------------
module jes_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [jes_pkg::THR_W-1:0]           threshold,
    input  logic [jes_pkg::DIM_W-1:0]           n_last,
    input  logic                                size_wr,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [jes_pkg::DATA_W-1:0]   s_element,
    output logic                                m_valid,
    input  logic                                m_ready,
    output jes_pkg::res_t                       m_result
);
    import jes_pkg::*;

    typedef enum logic [17:0] {
        ST_LOAD      = 18'h00001,
        ST_INIT      = 18'h00002,
        ST_SCAN      = 18'h00004,
        ST_SCAN_TAIL = 18'h00008,
        ST_CHECK     = 18'h00010,
        ST_DIAG_RD   = 18'h00020,
        ST_CORDIC    = 18'h00040,
        ST_MUL       = 18'h00080,
        ST_ACC       = 18'h00100,
        ST_FIN       = 18'h00200,
        ST_WR2       = 18'h00400,
        ST_T_NEXT    = 18'h00800,
        ST_T_RD      = 18'h01000,
        ST_V_NEXT    = 18'h02000,
        ST_V_RD      = 18'h04000,
        ST_E_RD      = 18'h08000,
        ST_E_LD      = 18'h10000,
        ST_E_WAIT    = 18'h20000
    } state_t;

    typedef enum logic [2:0] {
        G_CC, G_SS, G_CS, G_DII, G_DJJ, G_OFF, G_A, G_B
    } grp_t;

    // stores
    logic signed [DATA_W-1:0] mat_mem [DEPTH];
    logic signed [DATA_W-1:0] vec_mem [DEPTH];
    logic                     mw_en, vw_en;
    logic [ADDR_W-1:0]        mw_addr, vw_addr, ma_addr, mb_addr, va_addr, vb_addr;
    logic signed [DATA_W-1:0] mw_data, vw_data, ma_q, mb_q, va_q, vb_q;

    state_t                   state_reg, state_next;
    grp_t                     grp_reg, grp_next;
    logic [1:0]               term_reg, term_next;
    logic [DIM_W-1:0]         ld_r_reg, ld_r_next, ld_c_reg, ld_c_next;
    logic [DIM_W-1:0]         sw_r_reg, sw_r_next, sw_c_reg, sw_c_next;
    logic [DIM_W-1:0]         t_reg, t_next;
    logic                     pend_reg, pend_next;
    logic [DIM_W-1:0]         pend_r_reg, pend_r_next, pend_c_reg, pend_c_next;
    logic                     have_best_reg, have_best_next;
    logic [DATA_W-1:0]        best_mag_reg, best_mag_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    logic [DIM_W-1:0]         bi_reg, bi_next, bj_reg, bj_next;
    logic [ROT_W-1:0]         rot_cnt_reg, rot_cnt_next;
    logic                     conv_reg, conv_next;
    logic                     vec_reg, vec_next;
    logic signed [DATA_W-1:0] p_reg, p_next, q_reg, q_next;
    logic signed [DATA_W-1:0] cp_reg, cp_next, sp_reg, sp_next;
    logic signed [DATA_W-1:0] cc_reg, cc_next, ss_reg, ss_next, cs_reg, cs_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    res_t                     out_reg, out_next;

    logic                     sw_last;
    logic [DATA_W-1:0]        scan_mag;
    logic [1:0]               last_term;

    // arithmetic units
    logic signed [MAC_A_W-1:0] op_a;
    logic signed [DATA_W-1:0]  op_b;
    mac_ctrl_t                 mac_ctrl;
    logic signed [DATA_W-1:0]  mac_floor, mac_round;
    logic                      cordic_start, cordic_done;
    logic signed [DATA_W:0]    cordic_x, cordic_y;
    rot_t                      cordic_res;

    jes_mac u_mac (
        .aclk    (aclk),
        .op_a    (op_a),
        .op_b    (op_b),
        .ctrl    (mac_ctrl),
        .floor_q (mac_floor),
        .round_q (mac_round)
    );

    jes_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_in    (cordic_x),
        .y_in    (cordic_y),
        .done    (cordic_done),
        .result  (cordic_res)
    );

    always_ff @(posedge aclk) begin
        if (mw_en) begin
            mat_mem[mw_addr] <= mw_data;
        end
        ma_q <= mat_mem[ma_addr];
        mb_q <= mat_mem[mb_addr];
    end

    always_ff @(posedge aclk) begin
        if (vw_en) begin
            vec_mem[vw_addr] <= vw_data;
        end
        va_q <= vec_mem[va_addr];
        vb_q <= vec_mem[vb_addr];
    end

    assign cordic_x = {ma_q[DATA_W-1], ma_q} - {mb_q[DATA_W-1], mb_q};
    assign cordic_y = {best_val_reg, 1'b0};
    assign sw_last  = (sw_r_reg == n_last) && (sw_c_reg == n_last);
    assign scan_mag = ma_q[DATA_W-1] ? (~ma_q + 1'b1) : ma_q;

    // operand selection per product term
    always_comb begin
        op_a        = '0;
        op_b        = '0;
        mac_ctrl    = '0;
        last_term   = 2'd1;
        unique case (grp_reg)
            G_CC: begin
                op_a = MAC_A_W'(cp_reg);
                op_b = cp_reg;
                last_term = 2'd0;
            end
            G_SS: begin
                op_a = MAC_A_W'(sp_reg);
                op_b = sp_reg;
                last_term = 2'd0;
            end
            G_CS: begin
                op_a = MAC_A_W'(cp_reg);
                op_b = sp_reg;
                last_term = 2'd0;
            end
            G_DII, G_DJJ: begin
                last_term = 2'd2;
                priority case (term_reg)
                    2'd0: begin
                        op_a = MAC_A_W'(p_reg);
                        op_b = (grp_reg == G_DII) ? cc_reg : ss_reg;
                    end
                    2'd1: begin
                        op_a = MAC_A_W'(q_reg);
                        op_b = (grp_reg == G_DII) ? ss_reg : cc_reg;
                    end
                    default: begin
                        op_a         = MAC_A_W'(best_val_reg);
                        op_b         = cs_reg;
                        mac_ctrl.dbl = 1'b1;
                        mac_ctrl.neg = (grp_reg == G_DJJ);
                    end
                endcase
            end
            G_OFF: begin
                if (term_reg == 2'd0) begin
                    op_a = MAC_A_W'(q_reg) - MAC_A_W'(p_reg);
                    op_b = cs_reg;
                end else begin
                    op_a = MAC_A_W'(best_val_reg);
                    op_b = cc_reg - ss_reg;
                end
            end
            G_A: begin
                op_a = MAC_A_W'((term_reg == 2'd0) ? p_reg : q_reg);
                op_b = (term_reg == 2'd0) ? cp_reg : sp_reg;
            end
            G_B: begin
                op_a = MAC_A_W'((term_reg == 2'd0) ? q_reg : p_reg);
                op_b = (term_reg == 2'd0) ? cp_reg : sp_reg;
                mac_ctrl.neg = (term_reg != 2'd0);
            end
        endcase
        mac_ctrl.mul   = (state_reg == ST_MUL);
        mac_ctrl.acc   = (state_reg == ST_ACC);
        mac_ctrl.first = (term_reg == 2'd0);
    end

    always_comb begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        term_next      = term_reg;
        ld_r_next      = ld_r_reg;
        ld_c_next      = ld_c_reg;
        sw_r_next      = sw_r_reg;
        sw_c_next      = sw_c_reg;
        t_next         = t_reg;
        pend_next      = 1'b0;
        pend_r_next    = pend_r_reg;
        pend_c_next    = pend_c_reg;
        have_best_next = have_best_reg;
        best_mag_next  = best_mag_reg;
        best_val_next  = best_val_reg;
        bi_next        = bi_reg;
        bj_next        = bj_reg;
        rot_cnt_next   = rot_cnt_reg;
        conv_next      = conv_reg;
        vec_next       = vec_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        cp_next        = cp_reg;
        sp_next        = sp_reg;
        cc_next        = cc_reg;
        ss_next        = ss_reg;
        cs_next        = cs_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mw_en          = 1'b0;
        mw_addr        = '0;
        mw_data        = mac_round;
        vw_en          = 1'b0;
        vw_addr        = '0;
        vw_data        = mac_round;
        ma_addr        = '0;
        mb_addr        = '0;
        va_addr        = '0;
        vb_addr        = '0;
        cordic_start   = 1'b0;

        // search: the first off-diagonal entry seeds the maximum
        if (pend_reg && pend_r_reg != pend_c_reg) begin
            if (!have_best_reg || scan_mag > best_mag_reg) begin
                have_best_next = 1'b1;
                best_mag_next  = scan_mag;
                best_val_next  = ma_q;
                bi_next        = pend_r_reg;
                bj_next        = pend_c_reg;
            end
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    mw_en   = 1'b1;
                    mw_addr = mk_addr(ld_r_reg, ld_c_reg);
                    mw_data = s_element;
                    if (ld_r_reg == n_last && ld_c_reg == n_last) begin
                        ld_r_next  = '0;
                        ld_c_next  = '0;
                        sw_r_next  = '0;
                        sw_c_next  = '0;
                        state_next = ST_INIT;
                    end else if (ld_c_reg == n_last) begin
                        ld_c_next = '0;
                        ld_r_next = ld_r_reg + 1'b1;
                    end else begin
                        ld_c_next = ld_c_reg + 1'b1;
                    end
                end
            end
            ST_INIT: begin
                vw_en   = 1'b1;
                vw_addr = mk_addr(sw_r_reg, sw_c_reg);
                vw_data = (sw_r_reg == sw_c_reg) ? Q24_ONE : '0;
                if (sw_last) begin
                    sw_r_next      = '0;
                    sw_c_next      = '0;
                    rot_cnt_next   = '0;
                    have_best_next = 1'b0;
                    state_next     = ST_SCAN;
                end else if (sw_c_reg == n_last) begin
                    sw_c_next = '0;
                    sw_r_next = sw_r_reg + 1'b1;
                end else begin
                    sw_c_next = sw_c_reg + 1'b1;
                end
            end
            ST_SCAN: begin
                ma_addr     = mk_addr(sw_r_reg, sw_c_reg);
                pend_next   = 1'b1;
                pend_r_next = sw_r_reg;
                pend_c_next = sw_c_reg;
                if (sw_last) begin
                    state_next = ST_SCAN_TAIL;
                end else if (sw_c_reg == n_last) begin
                    sw_c_next = '0;
                    sw_r_next = sw_r_reg + 1'b1;
                end else begin
                    sw_c_next = sw_c_reg + 1'b1;
                end
            end
            ST_SCAN_TAIL: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (best_mag_reg < {1'b0, threshold}) begin
                    conv_next  = 1'b1;
                    sw_r_next  = '0;
                    sw_c_next  = '0;
                    state_next = ST_E_RD;
                end else if (rot_cnt_reg >= ROT_W'(MAX_ROTATIONS)) begin
                    conv_next  = 1'b0;
                    sw_r_next  = '0;
                    sw_c_next  = '0;
                    state_next = ST_E_RD;
                end else begin
                    ma_addr    = mk_addr(bi_reg, bi_reg);
                    mb_addr    = mk_addr(bj_reg, bj_reg);
                    state_next = ST_DIAG_RD;
                end
            end
            ST_DIAG_RD: begin
                p_next       = ma_q;
                q_next       = mb_q;
                cordic_start = 1'b1;
                state_next   = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (cordic_done) begin
                    cp_next    = cordic_res.c;
                    sp_next    = cordic_res.s;
                    grp_next   = G_CC;
                    term_next  = '0;
                    vec_next   = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (term_reg == last_term) begin
                    state_next = ST_FIN;
                end else begin
                    term_next  = term_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN: begin
                term_next  = '0;
                state_next = ST_MUL;
                unique case (grp_reg)
                    G_CC: begin
                        cc_next  = mac_floor;
                        grp_next = G_SS;
                    end
                    G_SS: begin
                        ss_next  = mac_floor;
                        grp_next = G_CS;
                    end
                    G_CS: begin
                        cs_next  = mac_floor;
                        grp_next = G_DII;
                    end
                    G_DII: begin
                        mw_en    = 1'b1;
                        mw_addr  = mk_addr(bi_reg, bi_reg);
                        grp_next = G_DJJ;
                    end
                    G_DJJ: begin
                        mw_en    = 1'b1;
                        mw_addr  = mk_addr(bj_reg, bj_reg);
                        grp_next = G_OFF;
                    end
                    G_OFF: begin
                        mw_en      = 1'b1;
                        mw_addr    = mk_addr(bi_reg, bj_reg);
                        res_next   = mac_round;
                        state_next = ST_WR2;
                    end
                    G_A: begin
                        if (vec_reg) begin
                            vw_en    = 1'b1;
                            vw_addr  = mk_addr(t_reg, bi_reg);
                            grp_next = G_B;
                        end else begin
                            mw_en      = 1'b1;
                            mw_addr    = mk_addr(bi_reg, t_reg);
                            res_next   = mac_round;
                            state_next = ST_WR2;
                        end
                    end
                    G_B: begin
                        if (vec_reg) begin
                            vw_en   = 1'b1;
                            vw_addr = mk_addr(t_reg, bj_reg);
                            if (t_reg == n_last) begin
                                rot_cnt_next   = rot_cnt_reg + 1'b1;
                                sw_r_next      = '0;
                                sw_c_next      = '0;
                                have_best_next = 1'b0;
                                state_next     = ST_SCAN;
                            end else begin
                                t_next     = t_reg + 1'b1;
                                state_next = ST_V_NEXT;
                            end
                        end else begin
                            mw_en      = 1'b1;
                            mw_addr    = mk_addr(bj_reg, t_reg);
                            res_next   = mac_round;
                            state_next = ST_WR2;
                        end
                    end
                endcase
            end
            ST_WR2: begin
                // mirror the row result into the column
                mw_data = res_reg;
                case (grp_reg)
                    G_OFF: begin
                        mw_en      = 1'b1;
                        mw_addr    = mk_addr(bj_reg, bi_reg);
                        t_next     = '0;
                        state_next = ST_T_NEXT;
                    end
                    G_A: begin
                        mw_en      = 1'b1;
                        mw_addr    = mk_addr(t_reg, bi_reg);
                        grp_next   = G_B;
                        term_next  = '0;
                        state_next = ST_MUL;
                    end
                    G_B: begin
                        mw_en   = 1'b1;
                        mw_addr = mk_addr(t_reg, bj_reg);
                        if (t_reg == n_last) begin
                            t_next     = '0;
                            vec_next   = 1'b1;
                            state_next = ST_V_NEXT;
                        end else begin
                            t_next     = t_reg + 1'b1;
                            state_next = ST_T_NEXT;
                        end
                    end
                    default: begin
                        state_next = ST_LOAD;
                    end
                endcase
            end
            ST_T_NEXT: begin
                if (t_reg == bi_reg || t_reg == bj_reg) begin
                    if (t_reg == n_last) begin
                        t_next     = '0;
                        vec_next   = 1'b1;
                        state_next = ST_V_NEXT;
                    end else begin
                        t_next = t_reg + 1'b1;
                    end
                end else begin
                    ma_addr    = mk_addr(bi_reg, t_reg);
                    mb_addr    = mk_addr(bj_reg, t_reg);
                    state_next = ST_T_RD;
                end
            end
            ST_T_RD: begin
                p_next     = ma_q;
                q_next     = mb_q;
                grp_next   = G_A;
                term_next  = '0;
                state_next = ST_MUL;
            end
            ST_V_NEXT: begin
                va_addr    = mk_addr(t_reg, bi_reg);
                vb_addr    = mk_addr(t_reg, bj_reg);
                state_next = ST_V_RD;
            end
            ST_V_RD: begin
                p_next     = va_q;
                q_next     = vb_q;
                grp_next   = G_A;
                term_next  = '0;
                state_next = ST_MUL;
            end
            ST_E_RD: begin
                ma_addr    = mk_addr(sw_r_reg, sw_r_reg);
                va_addr    = mk_addr(sw_c_reg, sw_r_reg);
                state_next = ST_E_LD;
            end
            ST_E_LD: begin
                out_next.pair_index      = sw_r_reg;
                out_next.component_index = sw_c_reg;
                out_next.eigenvalue      = ma_q;
                out_next.component       = va_q;
                out_next.converged       = conv_reg;
                out_next.last            = sw_last;
                out_valid_next           = 1'b1;
                state_next               = ST_E_WAIT;
            end
            ST_E_WAIT: begin
                if (m_ready) begin
                    out_valid_next = 1'b0;
                    if (sw_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        if (sw_c_reg == n_last) begin
                            sw_c_next = '0;
                            sw_r_next = sw_r_reg + 1'b1;
                        end else begin
                            sw_c_next = sw_c_reg + 1'b1;
                        end
                        state_next = ST_E_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        // a size change drops a partial load
        if (size_wr) begin
            ld_r_next = '0;
            ld_c_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            ld_r_reg      <= '0;
            ld_c_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rot_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            ld_r_reg      <= ld_r_next;
            ld_c_reg      <= ld_c_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            rot_cnt_reg   <= rot_cnt_next;
        end
        grp_reg       <= grp_next;
        term_reg      <= term_next;
        sw_r_reg      <= sw_r_next;
        sw_c_reg      <= sw_c_next;
        t_reg         <= t_next;
        pend_r_reg    <= pend_r_next;
        pend_c_reg    <= pend_c_next;
        have_best_reg <= have_best_next;
        best_mag_reg  <= best_mag_next;
        best_val_reg  <= best_val_next;
        bi_reg        <= bi_next;
        bj_reg        <= bj_next;
        conv_reg      <= conv_next;
        vec_reg       <= vec_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        cp_reg        <= cp_next;
        sp_reg        <= sp_next;
        cc_reg        <= cc_next;
        ss_reg        <= ss_next;
        cs_reg        <= cs_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign s_ready  = (state_reg == ST_LOAD);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

`ifndef SYNTHESIS
    a_no_load_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");
    a_cordic_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == ST_CORDIC))
        else $error("angle finished outside its wait state");
    a_rot_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        rot_cnt_reg <= ROT_W'(MAX_ROTATIONS))
        else $error("rotation count beyond cap");
    a_check_has_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> have_best_reg)
        else $error("decision without a pivot");
    a_pivot_off_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIAG_RD) |-> (bi_reg != bj_reg))
        else $error("pivot on the diagonal");
`endif

endmodule

// ----- design/jacobi_eigen_solver.sv -----
// ----------------------------------------------------------------------------
// jacobi_eigen_solver: symmetric eigen-decomposition by Jacobi rotations
// Configuration registers, size clamping and stream packing around the
// solver core.
// ----------------------------------------------------------------------------
// Load an n-by-n matrix (n from the size register, clamped to 2..8) row-major,
// one Q8.24 element per item at one item a cycle. After the last element
// the block sweeps the vector store to identity, then runs rotations
// until the largest off-diagonal magnitude drops below threshold or 256
// rotations are done. In each rotation the search reads one store entry
// a cycle, the CORDIC normalises and then runs 62 steps, and every
// updated element takes a multiply and accumulate pass through the
// single shared multiplier. Results then leave one item at a time, each
// held until m_tready takes it, n*n items per job, pair-major, tlast on
// the final one. No input is taken from the end of the load until the
// final result is delivered.
module jacobi_eigen_solver (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [jes_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [jes_pkg::THR_W-1:0]          cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [jes_pkg::DATA_W-1:0]         s_tdata,   // [31:0] element
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] pair_index, [5:3] component_index, [37:6] eigenvalue,
    // [69:38] component, [71:70] zero
    output logic [jes_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tuser,   // [0] converged
    output logic                               m_tlast
);
    import jes_pkg::*;

    logic [THR_W-1:0]  threshold_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              size_wr;
    logic [DIM_W-1:0]  n_last;
    res_t              result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            size_reg      <= SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                CFG_SIZE:      size_reg      <= cfg_wdata[SIZE_W-1:0];
            endcase
        end
    end

    assign size_wr = cfg_wr_en && (cfg_addr == CFG_SIZE);

    always_comb begin
        if (size_reg < SIZE_W'(2)) begin
            n_last = DIM_W'(1);
        end else if (size_reg > SIZE_W'(MAX_DIM)) begin
            n_last = DIM_W'(MAX_DIM - 1);
        end else begin
            n_last = DIM_W'(size_reg - 1'b1);
        end
    end

    jes_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (threshold_reg),
        .n_last    (n_last),
        .size_wr   (size_wr),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_element (s_tdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {2'b00, result.component, result.eigenvalue,
                      result.component_index, result.pair_index};
    assign m_tuser = result.converged;
    assign m_tlast = result.last;

endmodule
